/* sv/sha_pkg.sv */
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LENGTH_OFFSET = 6'd56;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       init;       // load initial hash, clear fill and count
    logic       put_byte;   // write put_data at the fill position
    logic       count_byte; // advance the bit count by eight
    logic [7:0] put_data;
    logic       put_len;    // write the bit count into words 14 and 15
    logic       comp_start; // load working variables from the hash
    logic       round;      // run one round
    logic       comp_end;   // fold working variables into the hash
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
  } sha_stat_t;

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

endpackage

/* sv/sha_datapath.sv */
// SHA-256 datapath: block buffer, message schedule, working variables, hash.
`timescale 1ns / 1ps
module sha_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [2:0]        rd_index,
  output logic [31:0]       rd_word,
  output sha_pkg::sha_stat_t stat
);

  logic [31:0] hash [8];
  logic [31:0] wv [8];
  logic [31:0] w [16];     // block buffer, shifted as a schedule window
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [5:0]  round_idx;

  logic [31:0] s0, s1, w_new, t1, t2, e, a;
  logic [3:0]  widx;
  logic [4:0]  sh;

  always_comb begin
    s0 = sha_pkg::ror(w[1], 7) ^ sha_pkg::ror(w[1], 18) ^ (w[1] >> 3);
    s1 = sha_pkg::ror(w[14], 17) ^ sha_pkg::ror(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    e = wv[4];
    a = wv[0];
    t1 = wv[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
       + ((e & wv[5]) ^ (~e & wv[6])) + sha_pkg::K[round_idx] + w[0];
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
       + ((a & wv[1]) ^ (a & wv[2]) ^ (wv[1] & wv[2]));
    widx = fill[5:2];
    sh = {~fill[1:0], 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bit_count <= '0;
      round_idx <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::H_INIT[i];
    end else begin
      if (cmd.init) begin
        fill <= '0;
        bit_count <= '0;
        for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::H_INIT[i];
      end
      if (cmd.put_byte) begin
        w[widx] <= (w[widx] & ~(32'hff << sh)) | ({24'd0, cmd.put_data} << sh);
        fill <= fill + 6'd1;
      end
      if (cmd.count_byte) bit_count <= bit_count + 64'd8;
      if (cmd.put_len) begin
        w[14] <= bit_count[63:32];
        w[15] <= bit_count[31:0];
      end
      if (cmd.comp_start) begin
        round_idx <= '0;
        for (int i = 0; i < 8; i++) wv[i] <= hash[i];
      end
      if (cmd.round) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
        round_idx <= round_idx + 6'd1;
        wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
        wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
      end
      if (cmd.comp_end)
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
    end
  end

  assign rd_word = hash[rd_index];
  assign stat.fill = fill;
  assign stat.round_last = (round_idx == 6'd63);

endmodule

/* sv/sha_ctrl.sv */
// SHA-256 controller: byte sequencing, padding, rounds and digest output.
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_data,
  input  logic [2:0]         in_count,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_index,
  output sha_pkg::sha_cmd_t  cmd,
  input  sha_pkg::sha_stat_t stat
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_BYTES = 8'b0000_0010,
    S_PAD   = 8'b0000_0100,
    S_ZERO  = 8'b0000_1000,
    S_LEN   = 8'b0001_0000,
    S_ROUND = 8'b0010_0000,
    S_FOLD  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t      state, state_next;
  logic [31:0] data;
  logic [2:0]  left;
  logic        last;
  logic        padded;      // the pad byte has been written for this message
  logic        final_blk;   // the block being compressed is the last one
  logic [2:0]  idx;
  logic [2:0]  cnt_sat;

  assign cnt_sat = (in_count > 3'd4) ? 3'd4 : in_count;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_index = idx;

  always_comb begin
    cmd = '0;
    cmd.put_data = data[31:24];
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_BYTES;
      end
      S_BYTES: begin
        if (left != 3'd0) begin
          cmd.put_byte = 1'b1;
          cmd.count_byte = 1'b1;
          if (stat.fill == 6'd63) state_next = S_ROUND;
        end else if (last) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
        if (state_next == S_ROUND) cmd.comp_start = 1'b1;
      end
      S_PAD: begin
        cmd.put_byte = 1'b1;
        cmd.put_data = sha_pkg::PAD_BYTE;
        // A pad byte in the last slot completes the block on its own.
        if (stat.fill == 6'd63) begin
          cmd.comp_start = 1'b1;
          state_next = S_ROUND;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.put_data = 8'd0;
        if (stat.fill == sha_pkg::LENGTH_OFFSET && !final_blk) begin
          state_next = S_LEN;
        end else begin
          cmd.put_byte = 1'b1;
          if (stat.fill == 6'd63) begin
            cmd.comp_start = 1'b1;
            state_next = S_ROUND;
          end
        end
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        cmd.comp_start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (stat.round_last) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.comp_end = 1'b1;
        if (final_blk) state_next = S_OUT;
        else if (padded) state_next = S_ZERO;
        else state_next = S_BYTES;
      end
      S_OUT: begin
        if (out_ready && idx == 3'd7) begin
          cmd.init = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      left <= '0;
      last <= 1'b0;
      padded <= 1'b0;
      final_blk <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        data <= in_data;
        left <= cnt_sat;
        last <= in_last;
      end
      if (cmd.put_byte && state == S_BYTES) begin
        data <= {data[23:0], 8'd0};
        left <= left - 3'd1;
      end
      if (state == S_PAD) padded <= 1'b1;
      if (state == S_LEN) final_blk <= 1'b1;
      if (state == S_OUT && out_ready) idx <= idx + 3'd1;
      if (cmd.init) begin
        final_blk <= 1'b0;
        padded <= 1'b0;
        last <= 1'b0;
      end
    end
  end

endmodule

/* sv/sha256_stream_hasher.sv */
// Top level of the streaming SHA-256 hasher.
//
//  Channel | Direction | tdata                          | tuser / tlast
//  s_axis  | in        | [31:0] data_word               | tuser [2:0] bytes_valid,
//          |           |                                | tlast end_of_message
//  m_axis  | out       | [31:0] digest_word             | tuser [2:0] word_index,
//          |           |                                | tlast last_word
//
// One beat is handled at a time. Every full block adds the 64 rounds and a fold (the
// working variables load during the last byte write). An end-of-message beat adds
// padding and length writes, one or two compressions, then eight digest beats.
// Reset is synchronous, active high, and starts a fresh message. A stalled output
// holds the block in output state.
`timescale 1ns / 1ps
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] bytes_valid
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  sha_pkg::sha_cmd_t  cmd;
  sha_pkg::sha_stat_t stat;
  logic [2:0]         idx;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_count(s_axis_tuser), .in_last(s_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_index(idx),
    .cmd(cmd), .stat(stat)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .rd_index(idx),
    .rd_word(m_axis_tdata), .stat(stat)
  );

  // The digest word index doubles as the read address of the hash registers.
  assign m_axis_tuser = idx;
  assign m_axis_tlast = (idx == 3'd7);

endmodule
